### design/tour_length_euclidean_assert.svh
// Assertion macros shared by the tour length block.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef TOUR_LENGTH_EUCLIDEAN_ASSERT_SVH
`define TOUR_LENGTH_EUCLIDEAN_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLE_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TLE_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/tlen_pkg.sv
// Shared types, widths and codes for the tour length block.
// No dependencies; every module except tlen_sqrt imports this package.
package tlen_pkg;

  localparam int IDX_W          = 10;
  localparam int COORD_W        = 16;
  localparam int COST_W         = 27;
  localparam int MAX_CITIES_DEF = 1024;
  localparam int COORD_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TOUR = 1'b1;

  typedef logic [IDX_W-1:0]   city_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COST_W-1:0]  cost_t;

  // One classified word as it waits in the queue.
  typedef struct packed {
    logic   op;
    logic   in_range;
    logic   last;
    city_t  idx;
    coord_t x;
    coord_t y;
  } item_t;

  function automatic logic city_in_table(city_t c, int max_cities);
    return int'(c) < max_cities;
  endfunction

endpackage

### design/tlen_front.sv
// Front end: accepts input words, masks coordinates and checks the index range.
// Depends on tlen_pkg; feeds tlen_fifo.
module tlen_front #(
  parameter int MAX_CITIES = tlen_pkg::MAX_CITIES_DEF,
  parameter int COORD_BITS = tlen_pkg::COORD_BITS_DEF
) (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_opcode,
  input  tlen_pkg::city_t      in_city_index,
  input  tlen_pkg::coord_t     in_coord_x,
  input  tlen_pkg::coord_t     in_coord_y,
  input  logic                 in_last_city,
  input  logic                 q_full,
  output logic                 q_push,
  output tlen_pkg::item_t      q_item
);
  import tlen_pkg::*;

  localparam int     KEEP  = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam coord_t CMASK = coord_t'((33'd1 << KEEP) - 33'd1);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.op       = in_opcode;
    q_item.in_range = city_in_table(in_city_index, MAX_CITIES);
    q_item.last     = in_last_city;
    q_item.idx      = in_city_index;
    q_item.x        = in_coord_x & CMASK;
    q_item.y        = in_coord_y & CMASK;
  end

endmodule

### design/tlen_fifo.sv
// Short word queue between the front end and the leg engine.
// Depends on tlen_pkg and the assertion macro header.
`include "tour_length_euclidean_assert.svh"

module tlen_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tlen_pkg::item_t push_item,
  input  logic            pop,
  output tlen_pkg::item_t head,
  output logic            full,
  output logic            empty
);
  import tlen_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNT_W = PW + 1;

  item_t            slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head  = slot_r[rd_ptr_r];
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  `TLE_IMPLY(a_fifo_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "queue fill count beyond depth")
  `TLE_NEXT(a_fifo_drain, pop && !push, cnt_r == $past(cnt_r) - 1'b1, "pop did not drain queue")

endmodule

### design/tlen_sqrt.sv
// Iterative integer square root, one radicand bit pair per cycle.
// Gives floor root and remainder; depends on the assertion macro header.
`include "tour_length_euclidean_assert.svh"

module tlen_sqrt #(
  parameter int SW = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SW-1:0]        radicand,
  output logic                 done,
  output logic [(SW+1)/2-1:0]  root,
  output logic [(SW+1)/2+1:0]  rem
);
  localparam int NIT   = (SW + 1) / 2;
  localparam int PW    = 2 * NIT;
  localparam int REM_W = NIT + 2;
  localparam int CNT_W = $clog2(NIT);

  logic             run_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PW-1:0]    rad_r;
  logic [REM_W-1:0] rem_r;
  logic [NIT-1:0]   root_r;

  logic [REM_W-1:0] rem_sh, trial;
  logic             take;

  // Bring down the next bit pair and try the digit one.
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[PW-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign take   = (rem_sh >= trial);

  assign done = done_r;
  assign root = root_r;
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NIT - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= PW'(radicand);
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= take ? rem_sh - trial : rem_sh;
      root_r <= {root_r[NIT-2:0], take};
    end
  end

  `TLE_IMPLY(a_sqrt_rem, done_r, rem_r <= REM_W'({root_r, 1'b0}), "root remainder too large")

endmodule

### design/tlen_back.sv
// Leg engine: coordinate tables, leg distance, rounding and the running sum.
// Depends on tlen_pkg, tlen_sqrt and the assertion macro header.
`include "tour_length_euclidean_assert.svh"

module tlen_back #(
  parameter int MAX_CITIES = tlen_pkg::MAX_CITIES_DEF,
  parameter int COORD_BITS = tlen_pkg::COORD_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  tlen_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output tlen_pkg::cost_t out_tour_cost
);
  import tlen_pkg::*;

  localparam int TAB   = 1 << IDX_W;
  localparam int DEPTH = (MAX_CITIES < TAB) ? MAX_CITIES : TAB;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int SW    = 2 * CW + 1;
  localparam int NIT   = (SW + 1) / 2;
  localparam int REM_W = NIT + 2;
  localparam int DW    = NIT + 1;
  localparam int ACC_W = COST_W + 1;
  localparam cost_t SUM_MAX = '1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_DIFF = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       started_r, started_nxt;
  logic       close_r, close_nxt;
  logic       last_r, last_nxt;
  logic       outv_r, outv_nxt;
  cost_t      sum_r, sum_nxt;
  cost_t      cost_r, cost_nxt;
  city_t      first_r, first_nxt;
  city_t      prev_r, prev_nxt;
  city_t      a_idx_r, a_idx_nxt;
  city_t      b_idx_r, b_idx_nxt;

  logic [CW-1:0]   x_mem [DEPTH];
  logic [CW-1:0]   y_mem [DEPTH];
  logic [CW-1:0]   ax_q, ay_q, bx_q, by_q;
  logic            a_ok_q, b_ok_q;
  logic            mem_we;

  logic [CW-1:0]   ax, ay, bx, by;
  logic [CW-1:0]   dx_r, dy_r, dx_nxt, dy_nxt;
  logic [2*CW-1:0] sx_r, sy_r;

  logic             sq_start, sq_done;
  logic [SW-1:0]    sq_rad;
  logic [NIT-1:0]   sq_root;
  logic [REM_W-1:0] sq_rem;
  logic [DW-1:0]    leg_len;
  logic [ACC_W-1:0] acc;
  cost_t            sum_sat;

  assign mem_we = q_pop && (q_item.op == OP_LOAD) && q_item.in_range;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      x_mem[q_item.idx[AW-1:0]] <= q_item.x[CW-1:0];
      y_mem[q_item.idx[AW-1:0]] <= q_item.y[CW-1:0];
    end
    ax_q   <= x_mem[a_idx_r[AW-1:0]];
    ay_q   <= y_mem[a_idx_r[AW-1:0]];
    bx_q   <= x_mem[b_idx_r[AW-1:0]];
    by_q   <= y_mem[b_idx_r[AW-1:0]];
    a_ok_q <= city_in_table(a_idx_r, MAX_CITIES);
    b_ok_q <= city_in_table(b_idx_r, MAX_CITIES);
  end

  // A city beyond the table sits at the origin.
  assign ax = a_ok_q ? ax_q : '0;
  assign ay = a_ok_q ? ay_q : '0;
  assign bx = b_ok_q ? bx_q : '0;
  assign by = b_ok_q ? by_q : '0;
  assign dx_nxt = (ax > bx) ? ax - bx : bx - ax;
  assign dy_nxt = (ay > by) ? ay - by : by - ay;

  assign sq_start = (state_r == S_ADD);
  assign sq_rad   = SW'(sx_r) + SW'(sy_r);

  tlen_sqrt #(.SW(SW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root),
    .rem      (sq_rem)
  );

  // Nearest integer: round up when the remainder exceeds the floor root.
  assign leg_len = DW'(sq_root) + DW'(sq_rem > REM_W'(sq_root));
  assign acc     = ACC_W'(sum_r) + ACC_W'(leg_len);
  assign sum_sat = (acc > ACC_W'(SUM_MAX)) ? SUM_MAX : acc[COST_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    started_nxt = started_r;
    close_nxt   = close_r;
    last_nxt    = last_r;
    sum_nxt     = sum_r;
    cost_nxt    = cost_r;
    first_nxt   = first_r;
    prev_nxt    = prev_r;
    a_idx_nxt   = a_idx_r;
    b_idx_nxt   = b_idx_r;
    outv_nxt    = outv_r;
    q_pop       = 1'b0;
    if (outv_r && !out_stall) begin
      outv_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_item.op == OP_TOUR) begin
            if (!started_r) begin
              first_nxt   = q_item.idx;
              prev_nxt    = q_item.idx;
              sum_nxt     = '0;
              started_nxt = 1'b1;
              if (q_item.last) begin
                state_nxt = S_OUT;
              end
            end else begin
              a_idx_nxt = prev_r;
              b_idx_nxt = q_item.idx;
              prev_nxt  = q_item.idx;
              close_nxt = q_item.last;
              last_nxt  = q_item.last;
              state_nxt = S_RD;
            end
          end
        end
      end
      S_RD:   state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_SQ;
      S_SQ:   state_nxt = S_ADD;
      S_ADD:  state_nxt = S_ROOT;
      S_ROOT: begin
        if (sq_done) begin
          sum_nxt = sum_sat;
          if (close_r) begin
            // Closing leg from the final city back to the first one.
            close_nxt = 1'b0;
            a_idx_nxt = b_idx_r;
            b_idx_nxt = first_r;
            state_nxt = S_RD;
          end else if (last_r) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (!outv_r || !out_stall) begin
          outv_nxt    = 1'b1;
          cost_nxt    = sum_r;
          sum_nxt     = '0;
          started_nxt = 1'b0;
          last_nxt    = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      started_r <= 1'b0;
      close_r   <= 1'b0;
      last_r    <= 1'b0;
      outv_r    <= 1'b0;
      sum_r     <= '0;
      first_r   <= '0;
      prev_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
      close_r   <= close_nxt;
      last_r    <= last_nxt;
      outv_r    <= outv_nxt;
      sum_r     <= sum_nxt;
      first_r   <= first_nxt;
      prev_r    <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cost_r  <= cost_nxt;
    a_idx_r <= a_idx_nxt;
    b_idx_r <= b_idx_nxt;
    if (state_r == S_DIFF) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
    if (state_r == S_SQ) begin
      sx_r <= dx_r * dx_r;
      sy_r <= dy_r * dy_r;
    end
  end

  assign out_valid     = outv_r;
  assign out_tour_cost = cost_r;

  `TLE_IMPLY(a_back_idle_sum, !started_r, sum_r == '0, "running sum left over outside a tour")
  `TLE_IMPLY(a_back_out_src, $rose(outv_r), $past(state_r) == S_OUT, "result raised outside output step")
  `TLE_IMPLY(a_back_pop_idle, q_pop, state_r == S_IDLE && !q_empty, "queue popped while engine busy")

endmodule

### design/tour_length_euclidean.sv
// Channel  Direction  Ports
// in       input      in_valid, in_stall, in_opcode, in_city_index, in_coord_x, in_coord_y,
//                     in_last_city
// out      output     out_valid, out_stall, out_tour_cost
//
// A load word, or the first word of a tour, is taken in the idle state; each later tour word
// runs the read, difference, square, add and root steps; the last one of a tour runs them
// again for the closing leg, then the output step; the square root unit retires one bit pair a cycle.
// A four-word queue decouples input acceptance from the leg engine.
// Reset is synchronous; the coordinate tables are not cleared and have no clearing pass.
// The result sits in an output register and waits there while out_stall is high.
// Depends on tlen_pkg, tlen_front, tlen_fifo and tlen_back.
module tour_length_euclidean #(
  parameter int MAX_CITIES = tlen_pkg::MAX_CITIES_DEF,
  parameter int COORD_BITS = tlen_pkg::COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_opcode,
  input  tlen_pkg::city_t  in_city_index,
  input  tlen_pkg::coord_t in_coord_x,
  input  tlen_pkg::coord_t in_coord_y,
  input  logic             in_last_city,
  output logic             out_valid,
  input  logic             out_stall,
  output tlen_pkg::cost_t  out_tour_cost
);
  import tlen_pkg::*;

  logic  q_push, q_pop, q_full, q_empty;
  item_t q_in, q_head;

  tlen_front #(
    .MAX_CITIES (MAX_CITIES),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_city_index (in_city_index),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_last_city  (in_last_city),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  tlen_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  tlen_back #(
    .MAX_CITIES (MAX_CITIES),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_item        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tour_cost (out_tour_cost)
  );

endmodule

### verif/tour_cost_checker.sv
// Checker for the tour length block: watches the word and result channels,
// predicts every tour cost from its own coordinate tables and compares.
// Depends on tlen_pkg for the opcode codes and the field types.
module tour_cost_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             in_opcode,
  input  tlen_pkg::city_t  in_city_index,
  input  tlen_pkg::coord_t in_coord_x,
  input  tlen_pkg::coord_t in_coord_y,
  input  logic             in_last_city,
  input  logic             out_valid,
  input  logic             out_stall,
  input  tlen_pkg::cost_t  out_tour_cost,
  output int               fail_count,
  output int               pending_costs
);
  timeunit 1ns;
  timeprecision 1ps;

  import tlen_pkg::*;

  localparam logic [63:0] COST_CEILING = (64'd1 << COST_W) - 64'd1;

  coord_t      x_coords [MAX_CITIES_DEF];
  coord_t      y_coords [MAX_CITIES_DEF];
  city_t       tour_first;
  city_t       tour_prev;
  logic [63:0] cost_so_far;
  logic        in_tour;
  cost_t       expected_costs [$];

  initial begin
    fail_count    = 0;
    pending_costs = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: tour cost mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Nearest integer to the Euclidean distance: floor root found bit by bit,
  // then rounded up when the remainder exceeds the root.
  function automatic logic [63:0] rounded_distance(input city_t a, input city_t b);
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] sq;
    logic [63:0] root;
    logic [63:0] trial;
    dx = (x_coords[a] > x_coords[b]) ? x_coords[a] - x_coords[b] : x_coords[b] - x_coords[a];
    dy = (y_coords[a] > y_coords[b]) ? y_coords[a] - y_coords[b] : y_coords[b] - y_coords[a];
    sq = dx * dx + dy * dy;
    root = 64'd0;
    for (int bitpos = 17; bitpos >= 0; bitpos--) begin
      trial = root | (64'd1 << bitpos);
      if (trial * trial <= sq) root = trial;
    end
    if (sq - root * root > root) root = root + 64'd1;
    return root;
  endfunction

  function automatic logic [63:0] add_capped(input logic [63:0] total, input logic [63:0] d);
    return (total + d > COST_CEILING) ? COST_CEILING : total + d;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tour_first  = '0;
      tour_prev   = '0;
      cost_so_far = '0;
      in_tour     = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_opcode == OP_LOAD) begin
          x_coords[in_city_index] = in_coord_x;
          y_coords[in_city_index] = in_coord_y;
        end else begin
          if (!in_tour) begin
            tour_first  = in_city_index;
            tour_prev   = in_city_index;
            cost_so_far = '0;
            in_tour     = 1'b1;
          end else begin
            cost_so_far = add_capped(cost_so_far, rounded_distance(tour_prev, in_city_index));
            tour_prev   = in_city_index;
          end
          if (in_last_city) begin
            cost_so_far = add_capped(cost_so_far, rounded_distance(tour_prev, tour_first));
            expected_costs.push_back(cost_t'(cost_so_far));
            cost_so_far = '0;
            in_tour     = 1'b0;
          end
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_costs.size() == 0) begin
          report_mismatch($sformatf("unexpected cost %0d", out_tour_cost));
        end else if (out_tour_cost !== expected_costs[0]) begin
          report_mismatch($sformatf("cost %0d, predicted %0d", out_tour_cost,
                                    expected_costs[0]));
          void'(expected_costs.pop_front());
        end else begin
          void'(expected_costs.pop_front());
        end
      end
    end
    pending_costs = expected_costs.size();
  end

endmodule

### verif/tb_tour_length_euclidean.sv
// Testbench top for the tour length block: loads city tables and streams tours,
// with random idling on both channels. Depends on tlen_pkg, the block and
// tour_cost_checker, which does all prediction and comparison.
module tb_tour_length_euclidean;
  timeunit 1ns;
  timeprecision 1ps;

  import tlen_pkg::*;

  localparam int SETTLE_CYCLES = 120;
  localparam int LONG_HOLD     = 600;
  localparam int RANDOM_WORDS  = 250;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  logic  in_opcode;
  city_t in_city_index;
  coord_t in_coord_x;
  coord_t in_coord_y;
  logic  in_last_city;
  logic  out_valid;
  logic  out_stall;
  cost_t out_tour_cost;

  int    fail_count;
  int    pending_costs;

  // Sender and receiver idling switches, and the long hold-off request count.
  bit    tx_idle_on;
  bit    rx_idle_on;
  int    hold_requests;
  int    holds_done;
  int    words_sent;

  // Cities whose coordinates have been written; tours only visit these.
  bit    city_loaded [MAX_CITIES_DEF];
  city_t loaded_cities [$];

  tour_length_euclidean dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_city_index (in_city_index),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_last_city  (in_last_city),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tour_cost (out_tour_cost)
  );

  tour_cost_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_city_index (in_city_index),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_last_city  (in_last_city),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tour_cost (out_tour_cost),
    .fail_count    (fail_count),
    .pending_costs (pending_costs)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stall bursts, plus a long hold-off whenever one is requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one word and returns at the edge where it is taken. Stall is
  // sampled on the falling edge, when everything has settled.
  task automatic send_word(input logic op, input city_t idx, input coord_t x,
                           input coord_t y, input logic last);
    logic stalled;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_city_index <= idx;
    in_coord_x    <= x;
    in_coord_y    <= y;
    in_last_city  <= last;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    words_sent++;
  endtask

  task automatic load_city(input city_t idx, input coord_t x, input coord_t y);
    send_word(OP_LOAD, idx, x, y, 1'($urandom_range(0, 1)));
    if (!city_loaded[idx]) begin
      city_loaded[idx] = 1'b1;
      loaded_cities.push_back(idx);
    end
  endtask

  // Tour words carry junk in their coordinate fields, which the block ignores.
  task automatic visit_city(input city_t idx, input logic last);
    send_word(OP_TOUR, idx, coord_t'($urandom), coord_t'($urandom), last);
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? '1 : '0;
      1:       return coord_t'($urandom_range(0, 15));
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic city_t pick_loaded_city();
    return loaded_cities[$urandom_range(0, loaded_cities.size() - 1)];
  endfunction

  // A tour over already loaded cities, now and then with a load in between.
  task automatic random_tour(input int stops);
    for (int s = 0; s < stops; s++) begin
      if ($urandom_range(0, 9) == 0)
        load_city(city_t'($urandom), pick_coord(), pick_coord());
      visit_city(pick_loaded_city(), s == stops - 1);
    end
  endtask

  initial begin
    int random_start;
    bit pressure_done;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_LOAD;
    in_city_index = '0;
    in_coord_x    = '0;
    in_coord_y    = '0;
    in_last_city  = 1'b0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    hold_requests = 0;
    holds_done    = 0;
    words_sent    = 0;
    pressure_done = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corners of the coordinate square, a one-city tour, a zero leg and a
    // reload of the first city in the middle of a tour.
    load_city(10'd0, '0, '0);
    load_city(10'd1023, '1, '1);
    load_city(10'd1, '1, '0);
    load_city(10'd2, '0, '1);
    visit_city(10'd0, 1'b1);
    visit_city(10'd0, 1'b0);
    visit_city(10'd1023, 1'b1);
    visit_city(10'd0, 1'b0);
    visit_city(10'd1, 1'b0);
    visit_city(10'd2, 1'b1);
    load_city(10'd3, 16'd3, 16'd4);
    visit_city(10'd3, 1'b0);
    visit_city(10'd3, 1'b1);
    visit_city(10'd0, 1'b0);
    visit_city(10'd3, 1'b0);
    load_city(10'd0, 16'd6, 16'd8);
    visit_city(10'd1, 1'b1);
    load_city(10'd4, 16'd1, 16'd1);
    visit_city(10'd3, 1'b0);
    visit_city(10'd4, 1'b1);

    // Bouncing between opposite corners drives the running sum into saturation.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    load_city(10'd0, '0, '0);
    for (int n = 0; n < 1460; n++)
      visit_city((n % 2 == 0) ? 10'd0 : 10'd1023, n == 1459);

    random_start = words_sent;
    while (words_sent < random_start + RANDOM_WORDS) begin
      if (words_sent < random_start + RANDOM_WORDS - 80) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end else begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if (!pressure_done && words_sent > random_start + 80) begin
        // Results pile up behind the held receiver until the input stalls.
        pressure_done = 1'b1;
        hold_requests++;
        for (int n = 0; n < 40; n++)
          visit_city(pick_loaded_city(), 1'b1);
      end else if ($urandom_range(0, 2) == 0) begin
        load_city(city_t'($urandom), pick_coord(), pick_coord());
      end else begin
        random_tour($urandom_range(1, 12));
      end
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending_costs != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/tlen_pkg.sv
design/tlen_front.sv
design/tlen_fifo.sv
design/tlen_sqrt.sv
design/tlen_back.sv
design/tour_length_euclidean.sv
verif/tour_cost_checker.sv
verif/tb_tour_length_euclidean.sv
